/* sv/bbps_pkg.sv */
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared types and constants for the bicubic Bezier patch splitter.
// ----------------------------------------------------------------------------
package bbps_pkg;

  localparam int COORD_BITS  = 24;
  localparam int PATCH_PTS   = 16;
  localparam int OUT_PTS     = 64;
  localparam int OFIFO_DEPTH = 4;

  localparam int IDX_BITS   = $clog2(PATCH_PTS);
  localparam int N_BITS     = $clog2(OUT_PTS);
  localparam int OPTR_BITS  = $clog2(OFIFO_DEPTH);
  localparam int OCNT_BITS  = $clog2(OFIFO_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pt_t;

  // front to back: patch buffer status and read data
  typedef struct packed {
    pt_t  rdata;
    logic avail;
  } bbps_stat_t;

  // back to front: read address into the held patch and bank hand-back
  typedef struct packed {
    logic [IDX_BITS-1:0] rd_addr;
    logic                done_bank;
  } bbps_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_WAIT,
    ST_ROW_WR,
    ST_COL_RD,
    ST_COL_WAIT,
    ST_COL_WR,
    ST_EMIT
  } bbps_state_t;

endpackage

/* sv/bicubic_bezier_patch_split_top.sv */
// ----------------------------------------------------------------------------
// bicubic_bezier_patch_split_top
// Splits a bicubic Bezier patch at its midpoint into four sub-patches.
// throughput: one result per cycle while emitting and the result queue has room;
//   each patch is split as twelve curves (four rows, then eight columns)
//   through the shared halving unit, then its 64 results are emitted
// the two-bank point buffer takes the next patch while one is being split
// reset (rst_n low, synchronous) empties the buffer and the result queue
// ----------------------------------------------------------------------------
module bicubic_bezier_patch_split_top import bbps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] in_coord_x,
  input  logic [COORD_BITS-1:0] in_coord_y,
  input  logic [COORD_BITS-1:0] in_coord_z,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-1:0] out_z,
  output logic [1:0]            out_sub_patch,
  output logic [IDX_BITS-1:0]   out_point_index,
  output logic                  out_last_point
);

  pt_t        in_pt, out_pt;
  bbps_stat_t stat;
  bbps_req_t  req;

  assign in_pt.x = coord_t'(in_coord_x);
  assign in_pt.y = coord_t'(in_coord_y);
  assign in_pt.z = coord_t'(in_coord_z);

  bbps_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .in_pt (in_pt),
    .req   (req),
    .stat  (stat)
  );

  bbps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat            (stat),
    .req             (req),
    .pop             (pop),
    .empty           (empty),
    .out_pt          (out_pt),
    .out_sub_patch   (out_sub_patch),
    .out_point_index (out_point_index),
    .out_last_point  (out_last_point)
  );

  assign out_x = out_pt.x;
  assign out_y = out_pt.y;
  assign out_z = out_pt.z;

endmodule

/* sv/bbps_front.sv */
// ----------------------------------------------------------------------------
// bbps_front
// Collects control points into a two-bank patch buffer; a full bank is held
// for the back end until it hands the bank back.
// ----------------------------------------------------------------------------
module bbps_front import bbps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  pt_t        in_pt,
  input  bbps_req_t  req,
  output bbps_stat_t stat
);

  pt_t                 buf_mem [2*PATCH_PTS];
  pt_t                 rdata_r;
  logic                wr_bank_r, wr_bank_nxt;
  logic                rd_bank_r, rd_bank_nxt;
  logic [IDX_BITS-1:0] wr_idx_r, wr_idx_nxt;
  logic [1:0]          bank_v_r, bank_v_nxt;
  logic                accept;

  assign full   = bank_v_r[wr_bank_r];
  assign accept = push && !full;

  always_comb begin
    wr_bank_nxt = wr_bank_r;
    rd_bank_nxt = rd_bank_r;
    wr_idx_nxt  = wr_idx_r;
    bank_v_nxt  = bank_v_r;
    if (accept) begin
      wr_idx_nxt = wr_idx_r + 1'b1;
      if (wr_idx_r == IDX_BITS'(PATCH_PTS - 1)) begin
        bank_v_nxt[wr_bank_r] = 1'b1;
        wr_bank_nxt           = !wr_bank_r;
      end
    end
    // the bank handed back is never the one being filled
    if (req.done_bank) begin
      bank_v_nxt[rd_bank_r] = 1'b0;
      rd_bank_nxt           = !rd_bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_bank_r <= 1'b0;
      rd_bank_r <= 1'b0;
      wr_idx_r  <= '0;
      bank_v_r  <= '0;
    end else begin
      wr_bank_r <= wr_bank_nxt;
      rd_bank_r <= rd_bank_nxt;
      wr_idx_r  <= wr_idx_nxt;
      bank_v_r  <= bank_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_mem[{wr_bank_r, wr_idx_r}] <= in_pt;
    end
    rdata_r <= buf_mem[{rd_bank_r, req.rd_addr}];
  end

  assign stat.rdata = rdata_r;
  assign stat.avail = bank_v_r[rd_bank_r];

endmodule

/* sv/bbps_halve.sv */
// ----------------------------------------------------------------------------
// bbps_halve
// De Casteljau halving of one cubic: four points loaded one by one, three
// registered midpoint levels, eight points read out by select.
// ----------------------------------------------------------------------------
module bbps_halve import bbps_pkg::*; (
  input  logic       clk,
  input  logic       ld,
  input  logic [1:0] ld_idx,
  input  pt_t        ld_pt,
  input  logic [2:0] sel,
  output pt_t        q
);

  pt_t p_r [4];
  pt_t a_r, h_r, d_r;
  pt_t b_r, c_r;
  pt_t m_r;

  function automatic coord_t mid1(coord_t u, coord_t v);
    logic signed [COORD_BITS:0] s;
    s = {u[COORD_BITS-1], u} + {v[COORD_BITS-1], v};
    // floor of the mean: arithmetic shift of the widened sum
    return s[COORD_BITS:1];
  endfunction

  function automatic pt_t mid3(pt_t u, pt_t v);
    pt_t r;
    r.x = mid1(u.x, v.x);
    r.y = mid1(u.y, v.y);
    r.z = mid1(u.z, v.z);
    return r;
  endfunction

  // levels run every cycle; after the last load the three levels settle in turn
  always_ff @(posedge clk) begin
    if (ld) begin
      p_r[ld_idx] <= ld_pt;
    end
    a_r <= mid3(p_r[0], p_r[1]);
    h_r <= mid3(p_r[1], p_r[2]);
    d_r <= mid3(p_r[2], p_r[3]);
    b_r <= mid3(a_r, h_r);
    c_r <= mid3(h_r, d_r);
    m_r <= mid3(b_r, c_r);
  end

  always_comb begin
    case (sel)
      3'd0:    q = p_r[0];
      3'd1:    q = a_r;
      3'd2:    q = b_r;
      3'd3:    q = m_r;
      3'd4:    q = m_r;
      3'd5:    q = c_r;
      3'd6:    q = d_r;
      3'd7:    q = p_r[3];
      default: q = m_r;
    endcase
  end

endmodule

/* sv/bbps_back.sv */
// ----------------------------------------------------------------------------
// bbps_back
// Sequencer that splits the four rows, then the eight columns, through the
// shared halving unit, and streams the four sub-patches into a result queue.
// ----------------------------------------------------------------------------
module bbps_back import bbps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  bbps_stat_t          stat,
  output bbps_req_t           req,
  input  logic                pop,
  output logic                empty,
  output pt_t                 out_pt,
  output logic [1:0]          out_sub_patch,
  output logic [IDX_BITS-1:0] out_point_index,
  output logic                out_last_point
);

  typedef struct packed {
    pt_t                 pt;
    logic [1:0]          sp;
    logic [IDX_BITS-1:0] idx;
    logic                last;
  } orec_t;

  typedef struct packed {
    logic [1:0]          sp;
    logic [IDX_BITS-1:0] idx;
    logic                last;
  } meta_t;

  bbps_state_t state_r, state_nxt;
  logic [2:0]  curve_r, curve_nxt;
  logic [2:0]  seq_step_r, seq_step_nxt;
  logic [N_BITS-1:0] n_r, n_nxt;
  logic        ld_r, ld_nxt;
  logic        ld_col_r, ld_col_nxt;
  logic [1:0]  ld_idx_r;
  logic        split_we, cols_we, issue, done_bank;

  pt_t  split_mem [32];
  pt_t  cols_mem  [OUT_PTS];
  pt_t  split_rd_r, cols_rd_r;
  pt_t  hq, ld_pt;

  logic [N_BITS-1:0] cols_raddr;
  meta_t             meta_r;
  logic              infl_r;

  orec_t                 fifo_r [OFIFO_DEPTH];
  logic [OPTR_BITS-1:0]  wptr_r, rptr_r;
  logic [OCNT_BITS-1:0]  cnt_r, cnt_nxt, occ;
  logic                  fpush, fpop;

  assign occ = cnt_r + OCNT_BITS'(infl_r);

  always_comb begin
    state_nxt    = state_r;
    curve_nxt    = curve_r;
    seq_step_nxt = seq_step_r;
    n_nxt        = n_r;
    ld_nxt       = 1'b0;
    ld_col_nxt   = ld_col_r;
    split_we     = 1'b0;
    cols_we      = 1'b0;
    issue        = 1'b0;
    done_bank    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (stat.avail) begin
          state_nxt    = ST_ROW_RD;
          curve_nxt    = '0;
          seq_step_nxt = '0;
        end
      end
      ST_ROW_RD, ST_COL_RD: begin
        ld_nxt     = 1'b1;
        ld_col_nxt = (state_r == ST_COL_RD);
        if (seq_step_r == 3'd3) begin
          seq_step_nxt = '0;
          state_nxt    = (state_r == ST_COL_RD) ? ST_COL_WAIT : ST_ROW_WAIT;
        end else begin
          seq_step_nxt = seq_step_r + 3'd1;
        end
      end
      ST_ROW_WAIT, ST_COL_WAIT: begin
        // waits for the read data, the load and the three levels
        if (seq_step_r == 3'd3) begin
          seq_step_nxt = '0;
          state_nxt    = (state_r == ST_COL_WAIT) ? ST_COL_WR : ST_ROW_WR;
        end else begin
          seq_step_nxt = seq_step_r + 3'd1;
        end
      end
      ST_ROW_WR: begin
        split_we     = 1'b1;
        seq_step_nxt = seq_step_r + 3'd1;
        if (seq_step_r == 3'd7) begin
          if (curve_r == 3'd3) begin
            curve_nxt = '0;
            state_nxt = ST_COL_RD;
            done_bank = 1'b1;
          end else begin
            curve_nxt = curve_r + 3'd1;
            state_nxt = ST_ROW_RD;
          end
        end
      end
      ST_COL_WR: begin
        cols_we      = 1'b1;
        seq_step_nxt = seq_step_r + 3'd1;
        if (seq_step_r == 3'd7) begin
          curve_nxt = curve_r + 3'd1;
          if (curve_r == 3'd7) begin
            n_nxt     = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_COL_RD;
          end
        end
      end
      ST_EMIT: begin
        if (occ < OCNT_BITS'(OFIFO_DEPTH)) begin
          issue = 1'b1;
          n_nxt = n_r + 1'b1;
          if (n_r == N_BITS'(OUT_PTS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      curve_r    <= '0;
      seq_step_r <= '0;
      n_r        <= '0;
      ld_r       <= 1'b0;
      ld_col_r   <= 1'b0;
      infl_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      curve_r    <= curve_nxt;
      seq_step_r <= seq_step_nxt;
      n_r        <= n_nxt;
      ld_r       <= ld_nxt;
      ld_col_r   <= ld_col_nxt;
      infl_r     <= issue;
    end
  end

  assign req.rd_addr   = {curve_r[1:0], seq_step_r[1:0]};
  assign req.done_bank = done_bank;

  // row of the sub-patch point in the high bits, column in the low bits
  assign cols_raddr = {n_r[5], n_r[3:2], n_r[4], n_r[1:0]};

  always_ff @(posedge clk) begin
    ld_idx_r <= seq_step_r[1:0];
    if (split_we) begin
      split_mem[{curve_r[1:0], seq_step_r}] <= hq;
    end
    if (cols_we) begin
      cols_mem[{seq_step_r, curve_r}] <= hq;
    end
    split_rd_r <= split_mem[{seq_step_r[1:0], curve_r}];
    cols_rd_r  <= cols_mem[cols_raddr];
    meta_r.sp   <= n_r[5:4];
    meta_r.idx  <= n_r[3:0];
    meta_r.last <= (n_r == N_BITS'(OUT_PTS - 1));
  end

  assign ld_pt = ld_col_r ? split_rd_r : stat.rdata;

  bbps_halve u_halve (
    .clk    (clk),
    .ld     (ld_r),
    .ld_idx (ld_idx_r),
    .ld_pt  (ld_pt),
    .sel    (seq_step_r),
    .q      (hq)
  );

  // result queue
  assign fpush = infl_r;
  assign fpop  = pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (fpush && !fpop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (fpop && !fpush) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fpush) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (fpop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fpush) begin
      fifo_r[wptr_r] <= '{pt: cols_rd_r, sp: meta_r.sp, idx: meta_r.idx, last: meta_r.last};
    end
  end

  assign empty           = (cnt_r == '0);
  assign out_pt          = fifo_r[rptr_r].pt;
  assign out_sub_patch   = fifo_r[rptr_r].sp;
  assign out_point_index = fifo_r[rptr_r].idx;
  assign out_last_point  = fifo_r[rptr_r].last;

endmodule
